// ----- sv/brb_pkg.sv -----
package brb_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH       = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP        = 3'd2,
    MODE_PEEK       = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  localparam int unsigned DataW = 8;
  localparam int unsigned CountW = 8;

  // next contents of the result register, minus the read byte
  typedef struct packed {
    status_t             status;
    logic [CountW-1:0]   fill_count;
    logic                full_flag;
    logic                empty_flag;
    logic                rd_sel;
  } brb_result_t;

endpackage

// ----- sv/brb_mem.sv -----
module brb_mem #(
  parameter int unsigned AW = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [brb_pkg::DataW-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [brb_pkg::DataW-1:0] rd_data
);
  import brb_pkg::*;

  localparam int unsigned Entries = 2 ** AW;

  logic [DataW-1:0] mem_r [Entries];
  logic [DataW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/brb_ctrl.sv -----
module brb_ctrl #(
  parameter int unsigned AW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [2:0]                mode,
  input  logic [brb_pkg::DataW-1:0] data_in,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [brb_pkg::DataW-1:0] wr_data,
  output logic [AW-1:0]             rd_addr,
  output brb_pkg::brb_result_t      result
);
  import brb_pkg::*;

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          is_full, is_empty;
  logic          we;
  logic [AW-1:0] waddr;
  status_t       status;
  logic          rd_sel;
  logic [AW-1:0] cnt;
  logic [AW+CountW-1:0] cnt_ext;

  assign is_full  = (wr_ptr_r + AW'(1)) == rd_ptr_r;
  assign is_empty = wr_ptr_r == rd_ptr_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    we         = 1'b0;
    waddr      = wr_ptr_r;
    status     = STATUS_OK;
    rd_sel     = 1'b0;
    case (mode)
      MODE_PUSH: begin
        if (is_full) begin
          status = STATUS_FULL;
        end else begin
          we         = 1'b1;
          wr_ptr_nxt = wr_ptr_r + AW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          status = STATUS_FULL;
        end else begin
          we         = 1'b1;
          waddr      = rd_ptr_r - AW'(1);
          rd_ptr_nxt = rd_ptr_r - AW'(1);
        end
      end
      MODE_POP: begin
        if (is_empty) begin
          status = STATUS_EMPTY;
        end else begin
          rd_sel     = 1'b1;
          rd_ptr_nxt = rd_ptr_r + AW'(1);
        end
      end
      MODE_PEEK: begin
        if (is_empty) begin
          status = STATUS_EMPTY;
        end else begin
          rd_sel = 1'b1;
        end
      end
      MODE_CLEAR: begin
        wr_ptr_nxt = '0;
        rd_ptr_nxt = '0;
      end
      default: ;
    endcase
  end

  // count wraps mod DEPTH; only the low byte is reported
  assign cnt     = wr_ptr_nxt - rd_ptr_nxt;
  assign cnt_ext = {{CountW{1'b0}}, cnt};

  always_comb begin
    result.status     = status;
    result.fill_count = cnt_ext[CountW-1:0];
    result.full_flag  = (wr_ptr_nxt + AW'(1)) == rd_ptr_nxt;
    result.empty_flag = wr_ptr_nxt == rd_ptr_nxt;
    result.rd_sel     = rd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (accept) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  assign wr_en   = accept && we;
  assign wr_addr = waddr;
  assign wr_data = data_in;
  assign rd_addr = rd_ptr_r;

endmodule

// ----- sv/byte_ring_buffer_with_push_front.sv -----
// Byte queue in a ring of DEPTH entries (power of two, 2 to 65536); holds at
// most DEPTH-1 bytes. Every accepted operation (push, push front, pop, peek,
// clear) yields one registered result beat, and a new operation can be
// taken every cycle while the result register is free or being drained. The
// pointer update and the result are one pass of logic into the result
// register; the popped byte comes from the ring's registered read port, read
// at the same edge. No clearing pass after reset: unwritten entries are never
// read.
module byte_ring_buffer_with_push_front #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_mode,
  input  logic [brb_pkg::DataW-1:0]  in_data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [brb_pkg::DataW-1:0]  out_data_out,
  output logic [brb_pkg::CountW-1:0] out_fill_count,
  output logic                       out_full_flag,
  output logic                       out_empty_flag
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [DataW-1:0] rd_data;
  brb_result_t      result;
  brb_result_t      res_r;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  brb_ctrl #(.AW(AW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_mode),
    .data_in (in_data_in),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .result  (result)
  );

  brb_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_data_out   = res_r.rd_sel ? rd_data : '0;
  assign out_fill_count = res_r.fill_count;
  assign out_full_flag  = res_r.full_flag;
  assign out_empty_flag = res_r.empty_flag;

endmodule

// ----- sv/brb_checker.sv -----
module brb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [brb_pkg::DataW-1:0]  out_data_out,
  input logic [brb_pkg::CountW-1:0] out_fill_count,
  input logic                       out_full_flag,
  input logic                       out_empty_flag
);
  import brb_pkg::*;

  // a held result beat must not drop
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_full_flag && out_empty_flag))
    else $error("full and empty both set");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_flag |-> out_fill_count == '0)
    else $error("empty with nonzero count");

  // a refused op leaves the state that caused the refusal
  a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != STATUS_FULL || out_full_flag) &&
                  (out_status != STATUS_EMPTY || out_empty_flag))
    else $error("refusal status disagrees with flags");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_data_out == '0)
    else $error("data on refused beat");

endmodule

bind byte_ring_buffer_with_push_front brb_checker u_brb_checker (.*);

// ----- dv/tb_byte_ring_buffer_with_push_front.sv -----
module tb_byte_ring_buffer_with_push_front;
  import brb_pkg::*;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  // modes with no operation behind them
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST = 3'd7;

  typedef struct {
    status_t            status;
    logic [DataW-1:0]   data;
    logic [CountW-1:0]  fill;
    logic               full;
    logic               empty;
  } queue_report_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode = '0;
  logic [DataW-1:0]   in_data_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [DataW-1:0]   out_data_out;
  logic [CountW-1:0]  out_fill_count;
  logic               out_full_flag;
  logic               out_empty_flag;

  // predicted ring contents and pointers
  logic [DataW-1:0]   ring_bytes [RING_DEPTH];
  logic [PtrW-1:0]    head_pos = '0;
  logic [PtrW-1:0]    tail_pos = '0;
  queue_report_t      pending_reports[$];

  int  fail_count = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;

  byte_ring_buffer_with_push_front #(
    .DEPTH(RING_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_fill_count (out_fill_count),
    .out_full_flag  (out_full_flag),
    .out_empty_flag (out_empty_flag)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int held_bytes();
    return int'(PtrW'(head_pos - tail_pos));
  endfunction

  // apply one operation to the predicted ring and queue up its report
  function automatic void predict_ring_op(input logic [2:0] mode, input logic [DataW-1:0] value);
    queue_report_t    rep;
    logic [PtrW-1:0]  head_next;
    head_next = head_pos + 1'b1;
    rep.status = STATUS_OK;
    rep.data = '0;
    case (mode)
      MODE_PUSH, MODE_PUSH_FRONT: begin
        if (head_next == tail_pos) begin
          rep.status = STATUS_FULL;
        end else if (mode == MODE_PUSH) begin
          ring_bytes[head_pos] = value;
          head_pos = head_next;
        end else begin
          tail_pos = tail_pos - 1'b1;
          ring_bytes[tail_pos] = value;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (head_pos == tail_pos) begin
          rep.status = STATUS_EMPTY;
        end else begin
          rep.data = ring_bytes[tail_pos];
          if (mode == MODE_POP) tail_pos = tail_pos + 1'b1;
        end
      end
      MODE_CLEAR: begin
        head_pos = '0;
        tail_pos = '0;
      end
      default: ;
    endcase
    head_next = head_pos + 1'b1;
    rep.fill = CountW'(PtrW'(head_pos - tail_pos));
    rep.full = (head_next == tail_pos);
    rep.empty = (head_pos == tail_pos);
    pending_reports.push_back(rep);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // valid stays high into the next beat when there is no gap
  task automatic send_op(input logic [2:0] mode, input logic [DataW-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_in <= value;
    do @(posedge clk); while (in_stall);
    predict_ring_op(mode, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_op(MODE_PEEK, 8'h3C);
    send_op(MODE_POP, 8'hC3);
    send_op(MODE_PUSH, 8'h00);
    send_op(MODE_PUSH, 8'hFF);
    send_op(MODE_PUSH_FRONT, 8'hA5);
    send_op(MODE_PEEK, 8'h00);
    send_op(MODE_POP, 8'hFF);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      send_op(3'(m), 8'($urandom));
    end
    send_op(MODE_POP, 8'h00);
    send_op(MODE_POP, 8'h00);
    send_op(MODE_POP, 8'h00);
    send_op(MODE_PUSH, 8'h5A);
    // clear keeps the bytes but nothing may be read afterwards
    send_op(MODE_CLEAR, 8'hFF);
    send_op(MODE_PEEK, 8'h00);
    // push front right after clear wraps the tail to the top slot
    send_op(MODE_PUSH_FRONT, 8'h01);
    send_op(MODE_PUSH, 8'h80);
    send_op(MODE_PEEK, 8'h7F);
    send_op(MODE_POP, 8'h00);
    send_op(MODE_POP, 8'h00);
  endtask

  task automatic test_fill_and_overflow();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    while (held_bytes() < RING_DEPTH - 1) begin
      send_op($urandom_range(0, 1) ? MODE_PUSH : MODE_PUSH_FRONT, 8'($urandom));
    end
    send_op(MODE_PUSH, 8'hFF);
    send_op(MODE_PUSH_FRONT, 8'h00);
    send_op(MODE_PEEK, 8'($urandom));
    while (held_bytes() > 0) begin
      send_op($urandom_range(0, 4) == 0 ? MODE_PEEK : MODE_POP, 8'($urandom));
    end
    send_op(MODE_POP, 8'($urandom));
    send_op(MODE_PEEK, 8'($urandom));
  endtask

  // bursts of fills and drains with random content, some noise mixed in
  task automatic test_random_traffic(input int op_total);
    int sent;
    int burst;
    int kind;
    sent = 0;
    while (sent < op_total) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        if (kind < 5) begin
          send_op($urandom_range(0, 2) == 0 ? MODE_PUSH_FRONT : MODE_PUSH, 8'($urandom));
        end else if (kind < 9) begin
          send_op($urandom_range(0, 3) == 0 ? MODE_PEEK : MODE_POP, 8'($urandom));
        end else begin
          send_op(3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
      sent += burst;
    end
  endtask

  always @(posedge clk) begin : drive_out_stall
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!stall_on || roll < 65) begin
      out_stall <= 1'b0;
    end else if (roll < 93) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(5, 25);
    end
  end

  always @(posedge clk) begin : check_reports
    queue_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing pending");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_data_out !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, out_data_out);
          fail_count++;
        end
        if (out_fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, out_fill_count);
          fail_count++;
        end
        if (out_full_flag !== want.full) begin
          $error("full_flag: expected %0b, got %0b", want.full, out_full_flag);
          fail_count++;
        end
        if (out_empty_flag !== want.empty) begin
          $error("empty_flag: expected %0b, got %0b", want.empty, out_empty_flag);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 300000);
    $display("FAIL byte_ring_buffer_with_push_front");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    wait_drained();
    test_fill_and_overflow();
    wait_drained();
    test_random_traffic(60);
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS byte_ring_buffer_with_push_front");
    end else begin
      $display("FAIL byte_ring_buffer_with_push_front");
    end
    $finish;
  end

endmodule
